/* rtl/ocell_pkg.sv */
package ocell_pkg;

    // window and field widths
    localparam int WINDOW   = 3;
    localparam int SAMPLE_W = 16;
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MAG_W    = $clog2(WINDOW * 32768 + 1);
    localparam int SUM_W    = MAG_W + 1;
    localparam int LEVEL_W  = 16;
    localparam int CAL_W    = 16;
    localparam int REF_W    = 10;
    localparam int THR_W    = 14;
    localparam int DEB_W    = 16;
    localparam int ERR_W    = 17;
    localparam int TIME_W   = 32;
    localparam int ACT_W    = 16;
    localparam int O2_W     = 14;

    // level = mag / WINDOW by reciprocal multiply
    localparam int LVL_SHIFT = MAG_W + 3;
    localparam int RECIP_W   = LVL_SHIFT;
    localparam logic [RECIP_W-1:0] LVL_RECIP =
        RECIP_W'((2 ** LVL_SHIFT + WINDOW - 1) / WINDOW);

    // oxygen ratio divider
    localparam int NUM_W   = MAG_W + REF_W;
    localparam int DEN_W   = CAL_W + $clog2(WINDOW);
    localparam int LIM_W   = DEN_W + O2_W;
    localparam int DIV_W   = (NUM_W > LIM_W) ? NUM_W : LIM_W;
    localparam int QCNT_W  = $clog2(O2_W);
    localparam int O2_MAX  = 9999;
    localparam int SCALE   = WINDOW * (O2_MAX + 1);

    // button timing
    localparam int ACT_PRESS    = 17;
    localparam int ACT_HINT_MIN = 16;
    localparam int HOLD_MIN_MS  = 2;
    localparam int MS_PER_S     = 1000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_FIFO_W = $clog2(QUEUE_DEPTH + 1);

    // ports
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [THR_W-1:0] RST_ALARM_THR = THR_W'(400);
    localparam logic [REF_W-1:0] RST_REFERENCE = REF_W'(209);
    localparam logic [DEB_W-1:0] RST_DEBOUNCE  = DEB_W'(200);
    localparam logic [CAL_W-1:0] RST_CAL       = CAL_W'(0);
    localparam logic [ERR_W-1:0] RST_ERR_THR   = ERR_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_THR = 3'd0,
        CFG_REFERENCE = 3'd1,
        CFG_DEBOUNCE  = 3'd2,
        CFG_INIT_CAL  = 3'd3,
        CFG_ERR_THR   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HINT_NONE = 2'd0,
        HINT_CAL  = 2'd1,
        HINT_MODE = 2'd2
    } t_hint;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SUM,
        F_LVL,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SAT,
        B_DIV,
        B_OUT
    } t_back_state;

    typedef struct packed {
        logic [THR_W-1:0] alarm_thr;
        logic [REF_W-1:0] reference;
        logic [DEB_W-1:0] debounce;
        logic [ERR_W-1:0] err_thr;
    } t_cfg;

    // one classified item handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic [LEVEL_W-1:0] level;
        logic [CAL_W-1:0]   cal;
        logic               sensor_error;
        logic               mode;
        t_hint              hint;
        logic               hold;
        logic               captured;
    } t_job;

endpackage

/* rtl/oxygen_cell_analyzer.sv */
// oxygen cell analyzer: each input beat carries one cell sample, the button
// level and a millisecond timestamp, and yields exactly one output beat with
// the oxygen level in tenths of a percent (|window sum| * reference /
// (3 * calibration), truncated, saturated at 9999), the alarm and sensor
// error flags, the window average, the mode, the menu hint and the button
// actions. a front end takes one beat at a time through latch, window sum,
// level multiply and button handling, waits while the queue is full, and
// hands it through a two-entry queue to the back end, which works one beat
// at a time: pop, multiply, a saturation check, then a 14-step restoring
// divider (skipped when the result saturates), then the result register,
// which holds the beat until the output takes it. configuration is
// written through the cfg channel, which is always ready; writing
// initial_calibration also loads the calibration in use. write it only
// while no beat is in flight.
module oxygen_cell_analyzer import ocell_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample[15:0], button_released[16], time_ms[48:17], zero pad above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // o2_tenths[13:0], alarm[14], sensor_error[15], signal_level[31:16],
    // advanced_mode[32], menu_hint[34:33], hold_request[35], calibrated[36],
    // calibration_value[52:37], zero pad above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic cal_load;

    // front to queue
    logic push;
    t_job front_job;
    logic q_full;

    // queue to back
    logic pop;
    t_job head_job;
    logic q_empty;

    // back results
    logic [O2_W-1:0] o2;
    logic            alarm;
    t_job            res_job;

    assign o_cfg_ready = 1'b1;
    assign cal_load    = i_cfg_valid && (t_cfg_idx'(i_cfg_index) == CFG_INIT_CAL);

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_thr <= RST_ALARM_THR;
            r_cfg.reference <= RST_REFERENCE;
            r_cfg.debounce  <= RST_DEBOUNCE;
            r_cfg.err_thr   <= RST_ERR_THR;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALARM_THR: r_cfg.alarm_thr <= i_cfg_data[THR_W-1:0];
                CFG_REFERENCE: r_cfg.reference <= i_cfg_data[REF_W-1:0];
                CFG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data[DEB_W-1:0];
                CFG_ERR_THR:   r_cfg.err_thr   <= i_cfg_data[ERR_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    ocell_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_button    (s_axis_tdata[SAMPLE_W]),
        .i_time      (s_axis_tdata[SAMPLE_W+TIME_W:SAMPLE_W+1]),
        .i_cfg       (r_cfg),
        .i_cal_load  (cal_load),
        .i_cal_value (i_cfg_data[CAL_W-1:0]),
        .o_push      (push),
        .o_job       (front_job),
        .i_full      (q_full)
    );

    ocell_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ocell_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_o2        (o2),
        .o_alarm     (alarm),
        .o_job       (res_job)
    );

    // pack the result beat
    assign m_axis_tdata = {
        3'b000,
        res_job.cal,
        res_job.captured,
        res_job.hold,
        res_job.hint,
        res_job.mode,
        res_job.level,
        res_job.sensor_error,
        alarm,
        o2
    };

endmodule

/* rtl/ocell_fifo.sv */
module ocell_fifo import ocell_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      r_wr;
    logic [QPTR_W-1:0]      r_rd;
    logic [QCNT_FIFO_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] f_inc(input logic [QPTR_W-1:0] p);
        f_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == QCNT_FIFO_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_FIFO_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_FIFO_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/ocell_front.sv */
module ocell_front import ocell_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_button,
    input  logic [TIME_W-1:0]   i_time,
    input  t_cfg                i_cfg,
    input  logic                i_cal_load,
    input  logic [CAL_W-1:0]    i_cal_value,
    output logic                o_push,
    output t_job                o_job,
    input  logic                i_full
);

    t_front_state r_state;
    t_front_state n_state;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_button;
    logic [TIME_W-1:0]          r_time;

    logic signed [SAMPLE_W-1:0] r_win [WINDOW];
    logic signed [SAMPLE_W-1:0] n_win [WINDOW];
    logic [PTR_W-1:0]           r_ptr;
    logic [PTR_W-1:0]           n_ptr;
    logic [MAG_W-1:0]           r_mag;
    logic [MAG_W-1:0]           n_mag;
    logic [LEVEL_W-1:0]         r_level;
    logic [MAG_W+RECIP_W-1:0]   lvl_prod;

    logic [CAL_W-1:0]  r_cal;
    logic [CAL_W-1:0]  n_cal;
    logic              r_prev_btn;
    logic [TIME_W-1:0] r_press_time;
    logic [TIME_W-1:0] n_press_time;
    logic [ACT_W-1:0]  r_act;
    logic [ACT_W-1:0]  n_act;
    logic              r_mode;
    logic              n_mode;

    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] held;
    logic              press;
    logic              release_ok;
    logic              lt1;
    logic              lt2;
    logic              lt3;
    logic              weak_sig;
    logic [ACT_W-1:0]  act_mid;
    t_hint             hint;
    logic              hold;
    logic              captured;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_in_valid) n_state = F_SUM;
            F_SUM:  n_state = F_LVL;
            F_LVL:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        case (r_state)
            F_IDLE:  o_in_ready = 1'b1;
            F_PUSH:  o_push = !i_full;
            default: o_push = 1'b0;
        endcase
    end

    // window insert and magnitude of the sum
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < WINDOW; i++) begin
            n_win[i] = (r_ptr == PTR_W'(i)) ? r_sample : r_win[i];
            sum      = sum + SUM_W'(n_win[i]);
        end
        n_mag = (sum < 0) ? MAG_W'(-sum) : MAG_W'(sum);
        n_ptr = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
    end

    assign lvl_prod = (MAG_W+RECIP_W)'(r_mag) * (MAG_W+RECIP_W)'(LVL_RECIP);

    // press, release and hint
    always_comb begin
        since_press  = r_time - r_press_time;
        press        = !r_button && r_prev_btn && (since_press > TIME_W'(i_cfg.debounce));
        n_press_time = press ? r_time : r_press_time;
        act_mid      = press ? ACT_W'(ACT_PRESS) : r_act;
        held         = r_time - n_press_time;
        lt1          = held < TIME_W'(MS_PER_S);
        lt2          = held < TIME_W'(2 * MS_PER_S);
        lt3          = held < TIME_W'(3 * MS_PER_S);
        release_ok   = (held > TIME_W'(HOLD_MIN_MS)) && r_button && !r_prev_btn;
        hold         = 1'b0;
        captured     = 1'b0;
        n_cal        = r_cal;
        n_mode       = r_mode;
        if (release_ok) begin
            if (lt1) begin
                hold    = 1'b1;
                act_mid = '0;
            end else if (lt2) begin
                n_cal    = r_level;
                captured = 1'b1;
                act_mid  = '0;
            end else if (lt3) begin
                n_mode = !r_mode;
            end
        end
        weak_sig = (ERR_W'(r_mag) < i_cfg.err_thr);
        hint = HINT_NONE;
        if (!weak_sig && lt3 && (act_mid > ACT_W'(ACT_HINT_MIN))) begin
            if (!lt2) begin
                hint = HINT_MODE;
            end else if (!lt1) begin
                hint = HINT_CAL;
            end
        end
        n_act = act_mid + ACT_W'(1);
    end

    always_comb begin
        o_job.mag          = r_mag;
        o_job.level        = r_level;
        o_job.cal          = n_cal;
        o_job.sensor_error = weak_sig || (n_cal == '0);
        o_job.mode         = n_mode;
        o_job.hint         = hint;
        o_job.hold         = hold;
        o_job.captured     = captured;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_ptr        <= '0;
            r_cal        <= RST_CAL;
            r_prev_btn   <= 1'b1;
            r_press_time <= '0;
            r_act        <= '0;
            r_mode       <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == F_SUM) begin
                r_win <= n_win;
                r_ptr <= n_ptr;
            end
            if (o_push) begin
                r_prev_btn   <= r_button;
                r_press_time <= n_press_time;
                r_act        <= n_act;
                r_cal        <= n_cal;
                r_mode       <= n_mode;
            end
            if (i_cal_load) begin
                r_cal <= i_cal_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample <= i_sample;
            r_button <= i_button;
            r_time   <= i_time;
        end
        if (r_state == F_SUM) begin
            r_mag <= n_mag;
        end
        if (r_state == F_LVL) begin
            r_level <= LEVEL_W'(lvl_prod >> LVL_SHIFT);
        end
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(WINDOW - 1))
        else $error("window pointer out of range");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !(o_job.hold && o_job.captured))
        else $error("hold and capture on one release");

    a_capture_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.captured) |=> (r_cal == $past(r_level)))
        else $error("captured calibration differs from signal level");

endmodule

/* rtl/ocell_back.sv */
module ocell_back import ocell_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_job             i_job,
    output logic             o_pop,
    input  t_cfg             i_cfg,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [O2_W-1:0]  o_o2,
    output logic             o_alarm,
    output t_job             o_job
);

    t_back_state r_state;
    t_back_state n_state;

    t_job              r_job;
    logic [NUM_W-1:0]  r_num;
    logic [LIM_W-1:0]  r_lim;
    logic [DIV_W-1:0]  r_dsr;
    logic [DIV_W-1:0]  r_rem;
    logic [O2_W-1:0]   r_q;
    logic [QCNT_W-1:0] r_cnt;

    logic [NUM_W-1:0] num_c;
    logic [DEN_W-1:0] den_c;
    logic [LIM_W-1:0] lim_c;
    logic             sat;
    logic             ge;

    assign num_c = NUM_W'(r_job.mag) * NUM_W'(i_cfg.reference);
    assign den_c = DEN_W'(r_job.cal) * DEN_W'(WINDOW);
    assign lim_c = LIM_W'(r_job.cal) * LIM_W'(SCALE);
    assign sat   = DIV_W'(r_num) >= DIV_W'(r_lim);
    assign ge    = r_rem >= r_dsr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_empty) n_state = B_MUL;
            B_MUL:  n_state = B_SAT;
            B_SAT:  n_state = sat ? B_OUT : B_DIV;
            B_DIV:  if (r_cnt == '0) n_state = B_OUT;
            B_OUT:  if (i_res_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            B_IDLE:  o_pop = !i_empty;
            B_OUT:   o_res_valid = 1'b1;
            default: o_pop = 1'b0;
        endcase
    end

    assign o_o2    = r_q;
    assign o_alarm = r_q > i_cfg.alarm_thr;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // job capture, multiply, saturation check and restoring divide, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            B_MUL: begin
                r_num <= num_c;
                r_lim <= lim_c;
                r_dsr <= DIV_W'(den_c) << (O2_W - 1);
            end
            B_SAT: begin
                r_rem <= DIV_W'(r_num);
                r_q   <= sat ? O2_W'(O2_MAX) : '0;
                r_cnt <= QCNT_W'(O2_W - 1);
            end
            B_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_dsr;
                end
                r_q   <= {r_q[O2_W-2:0], ge};
                r_dsr <= r_dsr >> 1;
                r_cnt <= r_cnt - QCNT_W'(1);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    a_o2_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_q <= O2_W'(O2_MAX)))
        else $error("oxygen result above saturation");

    a_zero_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (r_job.cal == '0)) |-> (r_q == O2_W'(O2_MAX)))
        else $error("zero calibration not saturated");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && r_cnt == '0) |=> (r_state == B_OUT))
        else $error("divider did not finish");

endmodule

/* tb/tb_oxygen_cell_analyzer.sv */
`timescale 1ns / 1ps

module tb_oxygen_cell_analyzer;
    import ocell_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 4;
    // quiet time after every due reading has arrived
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int IDLE_PCT      = 32;
    localparam int RANDOM_ITEMS  = 610;
    localparam int RANDOM_PHASES = 5;
    localparam int STALL_CYCLES  = 300;
    localparam int BURST_ITEMS   = 12;
    // hang guard in ns, many times the slowest correct run
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    // one expected output beat
    typedef struct {
        logic [O2_W-1:0]    o2_tenths;
        logic               alarm;
        logic               sensor_error;
        logic [LEVEL_W-1:0] signal_level;
        logic               advanced_mode;
        t_hint              menu_hint;
        logic               hold_request;
        logic               calibrated;
        logic [CAL_W-1:0]   calibration_value;
    } t_reading;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // sample[15:0], button_released[16], time_ms[48:17], zero pad above
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // o2_tenths[13:0], alarm[14], sensor_error[15], signal_level[31:16],
    // advanced_mode[32], menu_hint[34:33], hold_request[35], calibrated[36],
    // calibration_value[52:37], zero pad above
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    oxygen_cell_analyzer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor copy of the register file
    logic [THR_W-1:0] alarm_thr;
    logic [REF_W-1:0] ref_tenths;
    logic [DEB_W-1:0] debounce;
    logic [CAL_W-1:0] init_cal;
    logic [ERR_W-1:0] err_thr;

    // predictor copy of the analyzer state
    logic signed [SAMPLE_W-1:0] cell_window [WINDOW];
    int unsigned                win_ptr;
    logic [CAL_W-1:0]           cal_in_use;
    logic                       btn_prev;
    logic [TIME_W-1:0]          press_ms;
    logic [ACT_W-1:0]           act_cnt;
    logic                       mode_adv;

    t_reading          o2_readings_due [$];
    int unsigned       mismatch_count = 0;
    int unsigned       items_sent = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    // no idling on either side while set
    bit                steady = 1'b0;
    // receiver hold-off request, taken over by the receiver process
    int unsigned       rx_hold_req = 0;
    int unsigned       rx_hold_left = 0;

    function automatic void reset_model();
        alarm_thr  = RST_ALARM_THR;
        ref_tenths = RST_REFERENCE;
        debounce   = RST_DEBOUNCE;
        init_cal   = RST_CAL;
        err_thr    = RST_ERR_THR;
        foreach (cell_window[k]) cell_window[k] = '0;
        win_ptr    = 0;
        cal_in_use = RST_CAL;
        btn_prev   = 1'b1;
        press_ms   = '0;
        act_cnt    = '0;
        mode_adv   = 1'b0;
    endfunction

    // advances the predictor by one sample and returns the beat it must produce
    function automatic t_reading predict_reading(input logic signed [SAMPLE_W-1:0] smp,
                                                 input logic btn,
                                                 input logic [TIME_W-1:0] now);
        t_reading          r;
        int                window_sum;
        int unsigned       window_mag;
        int unsigned       level_v;
        int unsigned       secs;
        int unsigned       o2_v;
        logic [TIME_W-1:0] held_ms;
        longint unsigned   ratio;
        logic              weak_sig;

        cell_window[win_ptr] = smp;
        win_ptr = (win_ptr + 1 >= WINDOW) ? 0 : win_ptr + 1;
        window_sum = 0;
        foreach (cell_window[k]) window_sum += cell_window[k];
        window_mag = (window_sum < 0) ? -window_sum : window_sum;
        level_v = window_mag / WINDOW;

        r.hold_request = 1'b0;
        r.calibrated   = 1'b0;

        // debounced press edge restarts the press timer
        held_ms = now - press_ms;
        if (!btn && btn_prev && held_ms > debounce) begin
            press_ms = now;
            act_cnt  = ACT_W'(ACT_PRESS);
        end
        held_ms = now - press_ms;
        secs = held_ms / MS_PER_S;

        // release edge: short press holds, 1-2 s captures, 2-3 s toggles mode
        if (held_ms > HOLD_MIN_MS && btn && !btn_prev) begin
            if (secs < 1) begin
                r.hold_request = 1'b1;
                act_cnt = '0;
            end else if (secs < 2) begin
                cal_in_use = CAL_W'(level_v);
                r.calibrated = 1'b1;
                act_cnt = '0;
            end else if (secs < 3) begin
                mode_adv = ~mode_adv;
            end
        end
        btn_prev = btn;

        if (cal_in_use == 0) begin
            o2_v = O2_MAX;
        end else begin
            ratio = (longint'(window_mag) * ref_tenths) / (longint'(WINDOW) * cal_in_use);
            o2_v = (ratio > O2_MAX) ? O2_MAX : int'(ratio);
        end
        weak_sig = (window_mag < err_thr);

        r.menu_hint = HINT_NONE;
        if (!weak_sig && secs < 3 && act_cnt > ACT_HINT_MIN) begin
            if (secs >= 2)
                r.menu_hint = HINT_MODE;
            else if (secs >= 1)
                r.menu_hint = HINT_CAL;
        end
        act_cnt = act_cnt + 1'b1;

        r.o2_tenths         = O2_W'(o2_v);
        r.alarm             = (o2_v > alarm_thr);
        r.sensor_error      = weak_sig || (cal_in_use == 0);
        r.signal_level      = LEVEL_W'(level_v);
        r.advanced_mode     = mode_adv;
        r.calibration_value = cal_in_use;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] jittered(
            input logic signed [SAMPLE_W-1:0] center);
        return SAMPLE_W'(int'(center) + int'($urandom_range(0, 16)) - 8);
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // one input beat; valid stays high afterwards so back-to-back beats need no gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic btn,
                               input logic [TIME_W-1:0] now);
        int unsigned gap;

        gap = 0;
        while (!steady && gap < 20 && $urandom_range(99) < IDLE_PCT) gap++;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, now, btn, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        o2_readings_due.push_back(predict_reading(smp, btn, now));
        items_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ALARM_THR: alarm_thr  = THR_W'(val);
            CFG_REFERENCE: ref_tenths = REF_W'(val);
            CFG_DEBOUNCE:  debounce   = DEB_W'(val);
            CFG_INIT_CAL: begin
                init_cal   = CAL_W'(val);
                cal_in_use = CAL_W'(val);
            end
            CFG_ERR_THR:   err_thr    = ERR_W'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every due reading, then let the pipe go quiet
    task automatic settle();
        int unsigned n;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (o2_readings_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (o2_readings_due.size() != 0) begin
            $error("%0d readings never arrived", o2_readings_due.size());
            mismatch_count += o2_readings_due.size();
            o2_readings_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // reset values: calibration is zero so o2 pins at 9999 with a sensor error
    task automatic test_reset_defaults();
        send_sample(16'sd120, 1'b1, 32'd10);
        send_sample(-16'sd45, 1'b1, 32'd210);
        send_sample(16'sd300, 1'b1, 32'd410);
        clock_ms = 32'd410;
    endtask

    // a full-scale negative window sum, positive samples after it, saturation, then a weak signal
    task automatic test_sample_extremes();
        settle();
        write_reg(CFG_INIT_CAL, 1000);
        write_reg(CFG_REFERENCE, 1000);
        write_reg(CFG_ERR_THR, 98304);
        repeat (3) begin
            clock_ms += 200;
            send_sample(-16'sd32768, 1'b1, clock_ms);
        end
        repeat (2) begin
            clock_ms += 200;
            send_sample(16'sd32767, 1'b1, clock_ms);
        end
        settle();
        write_reg(CFG_ERR_THR, 8);
        clock_ms += 200;
        send_sample(16'sd0, 1'b1, clock_ms);
        clock_ms += 200;
        send_sample(-16'sd1, 1'b1, clock_ms);
        clock_ms += 200;
        send_sample(16'sd1, 1'b1, clock_ms);
    endtask

    // every press class, debounce rejection and menu hints, across a timestamp wrap
    task automatic test_button_actions();
        // press/release script relative to a start just below the wrap
        int unsigned offs [16] = '{0, 100, 180, 1500, 2000, 3200, 3500, 4000,
                                   5200, 6100, 6500, 7000, 10100, 10600, 11000, 11002};
        bit          btns [16] = '{0, 1, 0, 1, 0, 0, 1, 0,
                                   0, 0, 1, 0, 0, 1, 0, 1};
        logic [TIME_W-1:0] start_ms;

        settle();
        write_reg(CFG_ALARM_THR, 400);
        write_reg(CFG_REFERENCE, 209);
        write_reg(CFG_DEBOUNCE, 200);
        write_reg(CFG_INIT_CAL, 1000);
        start_ms = 32'hFFFF_FFC0;
        foreach (offs[k]) begin
            clock_ms = start_ms + offs[k];
            send_sample(SAMPLE_W'(3000 + 7 * k), btns[k], clock_ms);
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        settle();
        rx_hold_req = STALL_CYCLES;
        steady = 1'b1;
        repeat (BURST_ITEMS) begin
            clock_ms += 200;
            send_sample(jittered(16'sd2500), 1'b1, clock_ms);
        end
        steady = 1'b0;
    endtask

    // mostly whole press/release sequences on a noisy cell level, some raw noise
    task automatic test_random_phases();
        int unsigned                phase_end;
        int unsigned                target;
        int unsigned                stride;
        logic signed [SAMPLE_W-1:0] base_s;
        logic [TIME_W-1:0]          t_press;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_ALARM_THR, 0);
                    write_reg(CFG_REFERENCE, 1000);
                    write_reg(CFG_DEBOUNCE, 0);
                    write_reg(CFG_INIT_CAL, 1);
                    write_reg(CFG_ERR_THR, 0);
                end
                1: begin
                    write_reg(CFG_ALARM_THR, 9999);
                    write_reg(CFG_REFERENCE, 1);
                    write_reg(CFG_DEBOUNCE, 65535);
                    write_reg(CFG_INIT_CAL, 32768);
                    write_reg(CFG_ERR_THR, 98304);
                end
                default: begin
                    write_reg(CFG_ALARM_THR, $urandom_range(0, 9999));
                    write_reg(CFG_REFERENCE, $urandom_range(1, 1000));
                    write_reg(CFG_DEBOUNCE, ($urandom_range(3) == 0) ?
                              $urandom_range(0, 65535) : $urandom_range(0, 400));
                    // zero calibration until the first capture in one phase
                    write_reg(CFG_INIT_CAL, (ph == 2) ? 0 : $urandom_range(0, 32768));
                    write_reg(CFG_ERR_THR, ($urandom_range(3) == 0) ?
                              $urandom_range(0, 98304) : $urandom_range(0, 2000));
                end
            endcase
            // one whole phase with no idling on either side
            steady = (ph == 3);
            phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 80) begin
                    base_s = $signed(SAMPLE_W'($urandom));
                    base_s = base_s >>> $urandom_range(0, 12);
                    case ($urandom_range(0, 4))
                        0:       target = $urandom_range(0, 2);
                        1:       target = $urandom_range(3, 999);
                        2:       target = $urandom_range(1000, 1999);
                        3:       target = $urandom_range(2000, 2999);
                        default: target = $urandom_range(3000, 6000);
                    endcase
                    repeat ($urandom_range(0, 2)) begin
                        clock_ms += $urandom_range(50, 400);
                        send_sample(jittered(base_s), 1'b1, clock_ms);
                    end
                    clock_ms += $urandom_range(1, 400);
                    t_press = clock_ms;
                    send_sample(jittered(base_s), 1'b0, clock_ms);
                    stride = $urandom_range(50, 400);
                    while (32'(clock_ms - t_press) + stride < target) begin
                        clock_ms += stride;
                        send_sample(jittered(base_s), 1'b0, clock_ms);
                        stride = $urandom_range(50, 400);
                    end
                    clock_ms = t_press + target;
                    send_sample(jittered(base_s), 1'b1, clock_ms);
                end else begin
                    if ($urandom_range(9) == 0)
                        clock_ms = $urandom;
                    else
                        clock_ms += $urandom_range(0, 1000);
                    send_sample(SAMPLE_W'($urandom), 1'($urandom), clock_ms);
                end
            end
        end
        steady = 1'b0;
    endtask

    // receiver: random idling, a counted hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare each output beat against the oldest due reading
    always @(posedge i_clk) begin : result_check
        t_reading got;
        t_reading want;

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.o2_tenths         = m_axis_tdata[13:0];
            got.alarm             = m_axis_tdata[14];
            got.sensor_error      = m_axis_tdata[15];
            got.signal_level      = m_axis_tdata[31:16];
            got.advanced_mode     = m_axis_tdata[32];
            got.menu_hint         = t_hint'(m_axis_tdata[34:33]);
            got.hold_request      = m_axis_tdata[35];
            got.calibrated        = m_axis_tdata[36];
            got.calibration_value = m_axis_tdata[52:37];
            if (o2_readings_due.size() == 0) begin
                $error("output beat with no reading due");
                mismatch_count++;
            end else begin
                want = o2_readings_due.pop_front();
                check_field("o2_tenths", want.o2_tenths, got.o2_tenths);
                check_field("alarm", want.alarm, got.alarm);
                check_field("sensor_error", want.sensor_error, got.sensor_error);
                check_field("signal_level", want.signal_level, got.signal_level);
                check_field("advanced_mode", want.advanced_mode, got.advanced_mode);
                check_field("menu_hint", want.menu_hint, got.menu_hint);
                check_field("hold_request", want.hold_request, got.hold_request);
                check_field("calibrated", want.calibrated, got.calibrated);
                check_field("calibration_value", want.calibration_value,
                            got.calibration_value);
            end
        end
    end

    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_sample_extremes();
        test_button_actions();
        test_backpressure();
        test_random_phases();
        settle();

        if (mismatch_count == 0)
            $display("oxygen_cell_analyzer verification clean");
        else
            $display("oxygen_cell_analyzer verification failed");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("oxygen_cell_analyzer verification failed");
        $finish;
    end

endmodule
